>>> hdl/sha1md_pkg.sv
// ---------------------------------------------------------------------------
// SHA-1 message digest unit: shared package
// Item and control types, round constants and sizes used by all parts.
// ---------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

   // Request queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QUEUE_CW-1:0] QUEUE_FULL = QUEUE_CW'(QUEUE_DEPTH);

   // Block and schedule geometry.
   localparam int unsigned BLOCK_BITS   = 512;
   localparam int unsigned SCHED_WORDS  = 16;
   localparam int unsigned CHAIN_WORDS  = 5;
   localparam logic [5:0]  LAST_BYTE    = 6'd63;
   localparam logic [5:0]  LEN_START    = 6'd56;
   localparam logic [2:0]  LEN_LAST     = 3'd7;
   localparam logic [6:0]  LAST_ROUND   = 7'd79;
   localparam logic [6:0]  ROUND_XOR1   = 7'd20;
   localparam logic [6:0]  ROUND_MAJ    = 7'd40;
   localparam logic [6:0]  ROUND_XOR2   = 7'd60;
   localparam logic [2:0]  LAST_WORD    = 3'd4;
   localparam logic [7:0]  PAD_BYTE     = 8'h80;
   localparam logic [7:0]  ZERO_BYTE    = 8'h00;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam logic [31:0] INIT_CHAIN [CHAIN_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_CH   = 32'h5A827999;
   localparam logic [31:0] K_XOR1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
   localparam logic [31:0] K_XOR2 = 32'hCA62C1D6;

   typedef enum logic {
      KIND_ABSORB,
      KIND_FINISH
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
   } item_type;

   typedef enum logic [1:0] {
      BK_ABSORB,
      BK_PAD,
      BK_DRAIN,
      BK_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      CP_IDLE,
      CP_ROUND,
      CP_ADD
   } comp_state_type;

   typedef struct packed {
      logic start;
      logic reset_chain;
   } comp_ctrl_type;

   typedef struct packed {
      logic busy;
   } comp_stat_type;

endpackage

`default_nettype wire

>>> hdl/sha1md_front.sv
// ---------------------------------------------------------------------------
// SHA-1 front end
// Accepts requests, tags each as absorb or finish and holds them in a short
// queue until the back end takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1md_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] data_byte
   input  wire logic                req_tuser,   // [0] cmd
   output logic                     item_valid,
   output sha1md_pkg::item_type     item,
   input  wire logic                item_pop
);

   sha1md_pkg::item_type                queue_ff [sha1md_pkg::QUEUE_DEPTH];
   logic [sha1md_pkg::QUEUE_AW-1:0]     head_ff, head_in;
   logic [sha1md_pkg::QUEUE_AW-1:0]     tail_ff, tail_in;
   logic [sha1md_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                                push, pop;
   sha1md_pkg::item_type                new_item;

   assign req_tready = (count_ff != sha1md_pkg::QUEUE_FULL);
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[head_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      new_item.kind = req_tuser ? sha1md_pkg::KIND_FINISH : sha1md_pkg::KIND_ABSORB;
      new_item.data = req_tdata;
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sha1md_compress.sv
// ---------------------------------------------------------------------------
// SHA-1 compression engine
// Runs one round per cycle over a sliding 16-word schedule window and adds
// the working words into the chaining words after the last round.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1md_compress (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sha1md_pkg::comp_ctrl_type ctrl,
   output sha1md_pkg::comp_stat_type    stat,
   input  wire logic [sha1md_pkg::BLOCK_BITS-1:0] block,
   output logic [31:0]                  chain [sha1md_pkg::CHAIN_WORDS]
);

   sha1md_pkg::comp_state_type state_ff, state_in;
   logic [6:0]  round_ff;
   logic [31:0] w_ff [sha1md_pkg::SCHED_WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] chain_ff [sha1md_pkg::CHAIN_WORDS];
   logic [31:0] fn, kc, mix, w_new, a_new;

   assign stat.busy = (state_ff != sha1md_pkg::CP_IDLE);

   always_comb begin
      if (round_ff < sha1md_pkg::ROUND_XOR1) begin
         fn = (b_ff & c_ff) | (~b_ff & d_ff);
         kc = sha1md_pkg::K_CH;
      end else if (round_ff < sha1md_pkg::ROUND_MAJ) begin
         fn = b_ff ^ c_ff ^ d_ff;
         kc = sha1md_pkg::K_XOR1;
      end else if (round_ff < sha1md_pkg::ROUND_XOR2) begin
         fn = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         kc = sha1md_pkg::K_MAJ;
      end else begin
         fn = b_ff ^ c_ff ^ d_ff;
         kc = sha1md_pkg::K_XOR2;
      end
      // The window holds W[t..t+15]; the word sixteen ahead comes from taps 13, 8, 2, 0.
      mix   = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {mix[30:0], mix[31]};
      a_new = {a_ff[26:0], a_ff[31:27]} + fn + e_ff + kc + w_ff[0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha1md_pkg::CP_IDLE: begin
            if (ctrl.start) begin
               state_in = sha1md_pkg::CP_ROUND;
            end
         end
         sha1md_pkg::CP_ROUND: begin
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               state_in = sha1md_pkg::CP_ADD;
            end
         end
         sha1md_pkg::CP_ADD: begin
            state_in = sha1md_pkg::CP_IDLE;
         end
         default: begin
            state_in = sha1md_pkg::CP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1md_pkg::CP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.reset_chain) begin
         for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
            chain_ff[i] <= sha1md_pkg::INIT_CHAIN[i];
         end
      end else if (state_ff == sha1md_pkg::CP_ADD) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
         chain_ff[4] <= chain_ff[4] + e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sha1md_pkg::CP_IDLE && ctrl.start) begin
         for (int i = 0; i < sha1md_pkg::SCHED_WORDS; i++) begin
            w_ff[i] <= block[sha1md_pkg::BLOCK_BITS-1-32*i -: 32];
         end
         a_ff     <= chain_ff[0];
         b_ff     <= chain_ff[1];
         c_ff     <= chain_ff[2];
         d_ff     <= chain_ff[3];
         e_ff     <= chain_ff[4];
         round_ff <= '0;
      end else if (state_ff == sha1md_pkg::CP_ROUND) begin
         for (int i = 0; i < sha1md_pkg::SCHED_WORDS - 1; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[sha1md_pkg::SCHED_WORDS-1] <= w_new;
         a_ff     <= a_new;
         b_ff     <= a_ff;
         c_ff     <= {b_ff[1:0], b_ff[31:2]};
         d_ff     <= c_ff;
         e_ff     <= d_ff;
         round_ff <= round_ff + 1'b1;
      end
   end

   assign chain = chain_ff;

endmodule

`default_nettype wire

>>> hdl/sha1md_back.sv
// ---------------------------------------------------------------------------
// SHA-1 back end
// Packs bytes into the block buffer, generates the padding on finish,
// hands full blocks to the compression engine and emits the digest words.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1md_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire sha1md_pkg::item_type item,
   output logic                      item_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata,
   output logic                      rsp_tlast
);

   sha1md_pkg::back_state_type state_ff, state_in;
   sha1md_pkg::comp_ctrl_type  ctrl;
   sha1md_pkg::comp_stat_type  stat;

   logic [sha1md_pkg::BLOCK_BITS-1:0] blk_ff;
   logic [5:0]  cnt_ff;
   logic        full_ff;
   logic [63:0] bits_ff;
   logic [63:0] len_ff;
   logic        pad_first_ff, pad_first_in;
   logic        len_mode_ff, len_mode_in;
   logic [2:0]  len_cnt_ff, len_cnt_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff;
   logic [2:0]  rsp_idx_ff;
   logic        rsp_last_ff;
   logic [31:0] chain [sha1md_pkg::CHAIN_WORDS];

   logic        put, bits_add, len_load, len_shift, emit_load;
   logic [7:0]  put_byte;

   sha1md_compress u_compress (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat),
      .block (blk_ff),
      .chain (chain)
   );

   always_comb begin
      state_in          = state_ff;
      put               = 1'b0;
      put_byte          = item.data;
      item_pop          = 1'b0;
      bits_add          = 1'b0;
      len_load          = 1'b0;
      len_shift         = 1'b0;
      emit_load         = 1'b0;
      pad_first_in      = pad_first_ff;
      len_mode_in       = len_mode_ff;
      len_cnt_in        = len_cnt_ff;
      emit_idx_in       = emit_idx_ff;
      ctrl.start        = full_ff && !stat.busy;
      ctrl.reset_chain  = 1'b0;
      case (state_ff)
         sha1md_pkg::BK_ABSORB: begin
            if (item_valid) begin
               if (item.kind == sha1md_pkg::KIND_FINISH) begin
                  item_pop     = 1'b1;
                  len_load     = 1'b1;
                  pad_first_in = 1'b1;
                  len_mode_in  = 1'b0;
                  len_cnt_in   = '0;
                  state_in     = sha1md_pkg::BK_PAD;
               end else if (!full_ff) begin
                  item_pop = 1'b1;
                  put      = 1'b1;
                  bits_add = 1'b1;
               end
            end
         end
         sha1md_pkg::BK_PAD: begin
            if (!full_ff) begin
               put = 1'b1;
               if (pad_first_ff) begin
                  put_byte     = sha1md_pkg::PAD_BYTE;
                  pad_first_in = 1'b0;
               end else if (len_mode_ff || cnt_ff == sha1md_pkg::LEN_START) begin
                  // The length goes out most significant byte first.
                  put_byte    = len_ff[63:56];
                  len_shift   = 1'b1;
                  len_mode_in = 1'b1;
                  len_cnt_in  = len_cnt_ff + 1'b1;
                  if (len_cnt_ff == sha1md_pkg::LEN_LAST) begin
                     state_in = sha1md_pkg::BK_DRAIN;
                  end
               end else begin
                  put_byte = sha1md_pkg::ZERO_BYTE;
               end
            end
         end
         sha1md_pkg::BK_DRAIN: begin
            if (!full_ff && !stat.busy) begin
               emit_idx_in = '0;
               state_in    = sha1md_pkg::BK_EMIT;
            end
         end
         sha1md_pkg::BK_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit_load   = 1'b1;
               emit_idx_in = emit_idx_ff + 1'b1;
               if (emit_idx_ff == sha1md_pkg::LAST_WORD) begin
                  // The last word is captured this cycle, so the chain may restart.
                  ctrl.reset_chain = 1'b1;
                  state_in         = sha1md_pkg::BK_ABSORB;
               end
            end
         end
         default: begin
            state_in = sha1md_pkg::BK_ABSORB;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1md_pkg::BK_ABSORB;
         cnt_ff       <= '0;
         full_ff      <= 1'b0;
         bits_ff      <= '0;
         pad_first_ff <= 1'b0;
         len_mode_ff  <= 1'b0;
         len_cnt_ff   <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_first_ff <= pad_first_in;
         len_mode_ff  <= len_mode_in;
         len_cnt_ff   <= len_cnt_in;
         emit_idx_ff  <= emit_idx_in;
         if (put) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == sha1md_pkg::LAST_BYTE) begin
               full_ff <= 1'b1;
            end
         end else if (ctrl.start) begin
            full_ff <= 1'b0;
         end
         if (len_load) begin
            bits_ff <= '0;
         end else if (bits_add) begin
            bits_ff <= bits_ff + sha1md_pkg::BITS_PER_BYTE;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         blk_ff <= {blk_ff[sha1md_pkg::BLOCK_BITS-9:0], put_byte};
      end
      if (len_load) begin
         len_ff <= bits_ff;
      end else if (len_shift) begin
         len_ff <= {len_ff[55:0], sha1md_pkg::ZERO_BYTE};
      end
      if (emit_load) begin
         rsp_word_ff <= chain[emit_idx_ff];
         rsp_idx_ff  <= emit_idx_ff;
         rsp_last_ff <= (emit_idx_ff == sha1md_pkg::LAST_WORD);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_idx_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> hdl/sha1_message_digest_unit.sv
// ---------------------------------------------------------------------------
// SHA-1 message digest unit
// Byte-stream SHA-1: absorbs message bytes, pads on finish and returns the
// 160-bit digest as five 32-bit words.
//
//   Channel  Direction  Payload
//   req_*    in         tdata[7:0] data_byte, tuser[0] cmd (1 = finish)
//   rsp_*    out        tdata[31:0] digest_word, tdata[34:32] word_index,
//                       tlast last_word
//
// The back end packs each byte into the block buffer; each full 64-byte block
// then holds the compression engine for a load step, 80 rounds and the chain
// add, which overlap the collection of the next block. A finish appends up to
// 72 pad bytes, waits for the last compression and emits one word per cycle
// on the response side while rsp_tready is high. Reset is synchronous and
// returns the block to the initial chain; a stall on either side only holds
// the queue or the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   input  wire logic        req_tuser,    // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,    // [31:0] digest_word, [34:32] word_index
   output logic             rsp_tlast
);

   logic                 item_valid;
   logic                 item_pop;
   sha1md_pkg::item_type item;

   sha1md_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   sha1md_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
